/* src/ssi_pkg.sv */
`timescale 1ns / 1ps
package ssi_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int NUM_W   = PROD_W + DIFF_W;
  localparam int QUO_W   = DIFF_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_a_start_x;
    logic signed [COORD_W-1:0] seg_a_start_y;
    logic signed [COORD_W-1:0] seg_a_end_x;
    logic signed [COORD_W-1:0] seg_a_end_y;
    logic signed [COORD_W-1:0] seg_b_start_x;
    logic signed [COORD_W-1:0] seg_b_start_y;
    logic signed [COORD_W-1:0] seg_b_end_x;
    logic signed [COORD_W-1:0] seg_b_end_y;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                      hit;
    logic [PROD_W-1:0]         den;
    logic [PROD_W-1:0]         tn;
    logic signed [DIFF_W-1:0]  dax;
    logic signed [DIFF_W-1:0]  day;
    logic signed [COORD_W-1:0] ax0;
    logic signed [COORD_W-1:0] ay0;
  } cls_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

/* src/ssi_front.sv */
`timescale 1ns / 1ps
module ssi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  ssi_pkg::in_t  in_data,
  output logic          cls_valid,
  output ssi_pkg::cls_t cls_data
);
  import ssi_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [DIFF_W-1:0] dax_r, day_r, dbx_r, dby_r, wx_r, wy_r;
  logic signed [DIFF_W-1:0] dax2_r, day2_r, dax3_r, day3_r;
  logic signed [COORD_W-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic signed [PROD_W-1:0] pd1_r, pd2_r, ps1_r, ps2_r, pt1_r, pt2_r;
  logic signed [SUM_W-1:0] den_r, sn_r, tn_r;
  logic signed [SUM_W-1:0] den_n, sn_n, tn_n;
  cls_t cls_r, cls_nxt;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // differences, products, cross sums
  always_ff @(posedge clk) begin
    dax_r <= DIFF_W'(in_data.seg_a_end_x) - DIFF_W'(in_data.seg_a_start_x);
    day_r <= DIFF_W'(in_data.seg_a_end_y) - DIFF_W'(in_data.seg_a_start_y);
    dbx_r <= DIFF_W'(in_data.seg_b_end_x) - DIFF_W'(in_data.seg_b_start_x);
    dby_r <= DIFF_W'(in_data.seg_b_end_y) - DIFF_W'(in_data.seg_b_start_y);
    wx_r  <= DIFF_W'(in_data.seg_a_start_x) - DIFF_W'(in_data.seg_b_start_x);
    wy_r  <= DIFF_W'(in_data.seg_a_start_y) - DIFF_W'(in_data.seg_b_start_y);
    ax1_r <= in_data.seg_a_start_x;
    ay1_r <= in_data.seg_a_start_y;

    pd1_r  <= dax_r * dby_r;
    pd2_r  <= dbx_r * day_r;
    ps1_r  <= dax_r * wy_r;
    ps2_r  <= day_r * wx_r;
    pt1_r  <= dbx_r * wy_r;
    pt2_r  <= dby_r * wx_r;
    dax2_r <= dax_r;
    day2_r <= day_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;

    den_r  <= SUM_W'(pd1_r) - SUM_W'(pd2_r);
    sn_r   <= SUM_W'(ps1_r) - SUM_W'(ps2_r);
    tn_r   <= SUM_W'(pt1_r) - SUM_W'(pt2_r);
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;

    cls_r <= cls_nxt;
  end

  // normalise the sign of the denominator, then range-test both numerators
  always_comb begin
    den_n = den_r[SUM_W-1] ? -den_r : den_r;
    sn_n  = den_r[SUM_W-1] ? -sn_r  : sn_r;
    tn_n  = den_r[SUM_W-1] ? -tn_r  : tn_r;
    cls_nxt.hit = (den_n != '0) && !sn_n[SUM_W-1] && (sn_n <= den_n)
                  && !tn_n[SUM_W-1] && (tn_n <= den_n);
    cls_nxt.den = den_n[PROD_W-1:0];
    cls_nxt.tn  = tn_n[PROD_W-1:0];
    cls_nxt.dax = dax3_r;
    cls_nxt.day = day3_r;
    cls_nxt.ax0 = ax3_r;
    cls_nxt.ay0 = ay3_r;
  end

  assign cls_valid = v4_r;
  assign cls_data  = cls_r;

endmodule

/* src/ssi_fifo.sv */
`timescale 1ns / 1ps
module ssi_fifo #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ssi_pkg::qctl_t ctl,
  input  ssi_pkg::cls_t wr_data,
  output ssi_pkg::cls_t rd_data,
  output logic          empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import ssi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (ctl.pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!ctl.push && ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rp_r];
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push && !ctl.pop |-> cnt_r < CW'(DEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cnt_r != '0)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* src/ssi_back.sv */
`timescale 1ns / 1ps
module ssi_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  ssi_pkg::cls_t req_data,
  output logic          out_valid,
  output ssi_pkg::out_t out_data
);
  import ssi_pkg::*;

  typedef struct packed {
    logic                      hit;
    logic                      sx;
    logic                      sy;
    logic [PROD_W-1:0]         den;
    logic [NUM_W-1:0]          rx;
    logic [NUM_W-1:0]          ry;
    logic [QUO_W-1:0]          qx;
    logic [QUO_W-1:0]          qy;
    logic signed [COORD_W-1:0] ax0;
    logic signed [COORD_W-1:0] ay0;
  } div_t;

  cls_t b0_r;
  logic b0v_r, b1v_r;
  div_t b1_r;
  logic [DIFF_W-1:0] max_c, may_c;
  logic dv_r [QUO_W];
  div_t ds_r [QUO_W];
  div_t ds_in [QUO_W];
  logic ov_r;
  out_t out_r, out_nxt;
  logic signed [QUO_W:0] qsx, qsy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0v_r <= 1'b0;
      b1v_r <= 1'b0;
    end else begin
      b0v_r <= req_valid;
      b1v_r <= b0v_r;
    end
  end

  always_comb begin
    max_c = b0_r.dax[DIFF_W-1] ? DIFF_W'(-b0_r.dax) : DIFF_W'(b0_r.dax);
    may_c = b0_r.day[DIFF_W-1] ? DIFF_W'(-b0_r.day) : DIFF_W'(b0_r.day);
  end

  // latch the request, then form both numerator magnitudes
  always_ff @(posedge clk) begin
    b0_r     <= req_data;
    b1_r.hit <= b0_r.hit;
    b1_r.sx  <= b0_r.dax[DIFF_W-1];
    b1_r.sy  <= b0_r.day[DIFF_W-1];
    b1_r.den <= b0_r.den;
    b1_r.rx  <= b0_r.tn * max_c;
    b1_r.ry  <= b0_r.tn * may_c;
    b1_r.qx  <= '0;
    b1_r.qy  <= '0;
    b1_r.ax0 <= b0_r.ax0;
    b1_r.ay0 <= b0_r.ay0;
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int BIT = QUO_W - 1 - k;
    div_t src;
    logic [NUM_W-1:0] sh;
    logic src_v;
    assign src   = (k == 0) ? b1_r : ds_r[(k == 0) ? 0 : k - 1];
    assign src_v = (k == 0) ? b1v_r : dv_r[(k == 0) ? 0 : k - 1];
    assign sh    = NUM_W'(src.den) << BIT;

    always_comb begin
      ds_in[k] = src;
      if (src.rx >= sh) begin
        ds_in[k].rx      = src.rx - sh;
        ds_in[k].qx[BIT] = 1'b1;
      end
      if (src.ry >= sh) begin
        ds_in[k].ry      = src.ry - sh;
        ds_in[k].qy[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      ds_r[k] <= ds_in[k];
    end
  end

  // restore sign (truncation toward zero), offset by start of A
  always_comb begin
    qsx = ds_r[QUO_W-1].sx ? -$signed({1'b0, ds_r[QUO_W-1].qx})
                           :  $signed({1'b0, ds_r[QUO_W-1].qx});
    qsy = ds_r[QUO_W-1].sy ? -$signed({1'b0, ds_r[QUO_W-1].qy})
                           :  $signed({1'b0, ds_r[QUO_W-1].qy});
    out_nxt.hit     = ds_r[QUO_W-1].hit;
    out_nxt.cross_x = '0;
    out_nxt.cross_y = '0;
    if (ds_r[QUO_W-1].hit) begin
      out_nxt.cross_x = COORD_W'(ds_r[QUO_W-1].ax0 + COORD_W'(qsx));
      out_nxt.cross_y = COORD_W'(ds_r[QUO_W-1].ay0 + COORD_W'(qsy));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

/* src/segment_segment_intersection.sv */
`timescale 1ns / 1ps
// A request accepted at the input passes through the 4-stage classify front,
// the queue write, the request latch, a multiply stage, the 17-stage quotient
// pipeline and the output register.
// Throughput: one request per cycle while busy is low. Results strobe on
// out_valid for one cycle; the receiver cannot stall. Reset (rst_n low,
// synchronous) drops every request in flight.
module segment_segment_intersection #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ssi_pkg::in_t  in_data,
  output logic          out_valid,
  output ssi_pkg::out_t out_data
);
  import ssi_pkg::*;

  localparam int FRONT_STAGES = 4;
  localparam int CW           = $clog2(QUEUE_DEPTH + 1);
  localparam int LATENCY      = FRONT_STAGES + QUO_W + 4;

  logic  in_acc;
  logic  cls_valid;
  cls_t  cls_data;
  cls_t  q_data;
  logic  q_empty;
  logic [CW-1:0] q_count;
  qctl_t qctl;

  // credit: leave room for every request still inside the front
  assign busy   = q_count > CW'(QUEUE_DEPTH - FRONT_STAGES - 1);
  assign in_acc = start && !busy;

  ssi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .cls_valid(cls_valid),
    .cls_data (cls_data)
  );

  // the back never stalls, so pop whenever a request is waiting
  assign qctl.push = cls_valid;
  assign qctl.pop  = !q_empty;

  ssi_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (qctl),
    .wr_data(cls_data),
    .rd_data(q_data),
    .empty  (q_empty),
    .count  (q_count)
  );

  ssi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(qctl.pop),
    .req_data (q_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LATENCY out_valid)
    else $error("result missing at expected latency");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0)
    else $error("non-zero point on a miss");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cls_valid |-> q_count < CW'(QUEUE_DEPTH))
    else $error("front pushed into a full queue");
`endif

endmodule
